// ===== sv/bfpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition allocator package
// Shared types and constants of the allocator and its register block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfpa_pkg;

  localparam int unsigned AmountW = 12;
  localparam int unsigned OwnerW  = 4;
  localparam int unsigned BaseW   = 16;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [AmountW-1:0] MaxRequestReset = 12'hFFF;
  localparam logic RegMaxRequest = 1'b0;

  typedef enum logic [1:0] {
    ActDefine   = 2'd0,
    ActAllocate = 2'd1,
    ActRelease  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StatusOk         = 2'd0,
    StatusTooBig     = 2'd1,
    StatusMemoryFull = 2'd2,
    StatusTableFull  = 2'd3
  } status_e;

  typedef enum logic {
    StateIdle = 1'b0,
    StateScan = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [AmountW-1:0] amount;
    logic [OwnerW-1:0]  owner;
  } bfpa_item_t;

  typedef struct packed {
    status_e            status;
    logic [IndexW-1:0]  partition_index;
    logic [BaseW-1:0]   base_address;
    logic [CountW-1:0]  released_count;
  } bfpa_result_t;

  typedef struct packed {
    logic [AmountW-1:0] size;
    logic [BaseW-1:0]   base;
    logic               busy;
    logic [OwnerW-1:0]  owner;
  } slot_t;

endpackage

`default_nettype wire

// ===== sv/best_fit_partition_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition allocator
// Partition table in one synchronous memory, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// Define items and items rejected up front give their registered result in the
// cycle after the transaction, and a new item may follow in that cycle.
// Allocate and release items walk the n defined partitions through the
// registered memory read port and give their result once the last one is read.
// Reset clears the partition count and the running base and sets the size limit
// to 4095; the memory is not cleared since entries at or above the count are
// never read.
`default_nettype none

module best_fit_partition_allocator_unit #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire bfpa_pkg::bfpa_item_t            item_i,
  output logic                                 result_valid_o,
  output bfpa_pkg::bfpa_result_t               result_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfpa_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [bfpa_pkg::ApbDataW-1:0]   pwdata,
  output logic      [bfpa_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready
);
  import bfpa_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  logic [AmountW-1:0] max_request;

  bfpa_apb_regs u_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .max_request_size_o (max_request)
  );

  slot_t slot_mem [SLOTS];
  slot_t rdata_q;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_t           mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= slot_mem[mem_raddr];
    end
  end

  state_e             state_q, state_d;
  action_e            op_q, op_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [AmountW-1:0] amount_q, amount_d;
  logic [OwnerW-1:0]  owner_q, owner_d;
  logic               found_q, found_d;
  logic               busy_fit_q, busy_fit_d;
  logic [IdxW-1:0]    best_idx_q, best_idx_d;
  logic [AmountW-1:0] best_left_q, best_left_d;
  slot_t              best_q, best_d;
  logic [CntW-1:0]    rel_cnt_q, rel_cnt_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [BaseW-1:0]   next_base_q, next_base_d;
  logic               res_valid_q, res_valid_d;
  bfpa_result_t       res_q, res_d;

  logic               accept;
  logic               table_full;
  logic               last;
  logic               fits;
  logic [AmountW-1:0] left;
  logic               take;
  logic               hit;

  assign accept     = start && !busy;
  assign table_full = (count_q == CntW'(SLOTS));
  assign last       = (CntW'(ptr_q) == (count_q - CntW'(1)));
  assign fits       = (amount_q <= rdata_q.size);
  assign left       = rdata_q.size - amount_q;
  assign take       = fits && !rdata_q.busy && (!found_q || (left < best_left_q));
  assign hit        = rdata_q.busy && (rdata_q.owner == owner_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StateIdle: begin
        if (accept && (count_q != '0)) begin
          if ((item_i.action == ActAllocate) && (item_i.amount <= max_request)) begin
            state_d = StateScan;
          end else if (item_i.action == ActRelease) begin
            state_d = StateScan;
          end
        end
      end
      StateScan: begin
        if (last) begin
          state_d = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    ptr_d       = ptr_q;
    amount_d    = amount_q;
    owner_d     = owner_q;
    found_d     = found_q;
    busy_fit_d  = busy_fit_q;
    best_idx_d  = best_idx_q;
    best_left_d = best_left_q;
    best_d      = best_q;
    rel_cnt_d   = rel_cnt_q;
    count_d     = count_q;
    next_base_d = next_base_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    case (state_q)
      StateIdle: begin
        if (accept) begin
          res_valid_d = 1'b1;
          amount_d    = item_i.amount;
          owner_d     = item_i.owner;
          ptr_d       = '0;
          found_d     = 1'b0;
          busy_fit_d  = 1'b0;
          rel_cnt_d   = '0;
          case (action_e'(item_i.action))
            ActDefine: begin
              if (table_full) begin
                res_d.status = StatusTableFull;
              end else begin
                mem_we               = 1'b1;
                mem_waddr            = count_q[IdxW-1:0];
                mem_wdata.size       = item_i.amount;
                mem_wdata.base       = next_base_q;
                count_d              = count_q + CntW'(1);
                next_base_d          = next_base_q + BaseW'(item_i.amount);
                res_d.partition_index = IndexW'(count_q);
                res_d.base_address   = next_base_q;
              end
            end
            ActAllocate: begin
              if ((item_i.amount > max_request) || (count_q == '0)) begin
                res_d.status = StatusTooBig;
              end else begin
                res_valid_d = 1'b0;
                op_d        = ActAllocate;
                mem_re      = 1'b1;
              end
            end
            ActRelease: begin
              if (count_q != '0) begin
                res_valid_d = 1'b0;
                op_d        = ActRelease;
                mem_re      = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StateScan: begin
        if (!last) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + IdxW'(1);
          ptr_d     = ptr_q + IdxW'(1);
        end
        if (op_q == ActRelease) begin
          if (hit) begin
            mem_we         = 1'b1;
            mem_waddr      = ptr_q;
            mem_wdata      = rdata_q;
            mem_wdata.busy = 1'b0;
            rel_cnt_d      = rel_cnt_q + CntW'(1);
          end
          if (last) begin
            res_valid_d          = 1'b1;
            res_d.released_count = CountW'(rel_cnt_d);
          end
        end else begin
          if (fits && rdata_q.busy) begin
            busy_fit_d = 1'b1;
          end
          if (take) begin
            found_d     = 1'b1;
            best_idx_d  = ptr_q;
            best_left_d = left;
            best_d      = rdata_q;
          end
          if (last) begin
            res_valid_d = 1'b1;
            if (found_d) begin
              mem_we                = 1'b1;
              mem_waddr             = best_idx_d;
              mem_wdata             = best_d;
              mem_wdata.busy        = 1'b1;
              mem_wdata.owner       = owner_q;
              res_d.partition_index = IndexW'(best_idx_d);
              res_d.base_address    = best_d.base;
            end else if (busy_fit_d) begin
              res_d.status = StatusMemoryFull;
            end else begin
              res_d.status = StatusTooBig;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      count_q     <= '0;
      next_base_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_base_q <= next_base_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    ptr_q       <= ptr_d;
    amount_q    <= amount_d;
    owner_q     <= owner_d;
    found_q     <= found_d;
    busy_fit_q  <= busy_fit_d;
    best_idx_q  <= best_idx_d;
    best_left_q <= best_left_d;
    best_q      <= best_d;
    rel_cnt_q   <= rel_cnt_d;
    res_q       <= res_d;
  end

  assign busy           = (state_q != StateIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SLOTS))
    else $error("partition count exceeds table size");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateScan) |-> (CntW'(ptr_q) < count_q))
    else $error("scan pointer beyond defined partitions");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (state_q == StateIdle))
    else $error("result strobe while scan is running");

  a_scan_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StateScan) && last) |=> res_valid_q)
    else $error("scan finished without a result");

endmodule

`default_nettype wire

// ===== sv/bfpa_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Allocator register block
// APB-style access to the request size limit register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfpa_apb_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bfpa_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [bfpa_pkg::ApbDataW-1:0]   pwdata,
  output logic      [bfpa_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready,
  output logic      [bfpa_pkg::AmountW-1:0]    max_request_size_o
);
  import bfpa_pkg::*;

  logic [AmountW-1:0] max_request_q;
  logic [AmountW-1:0] max_request_d;
  logic               sel_max;
  logic               wr_en;

  assign pready  = 1'b1;
  assign sel_max = (paddr[ApbAddrW-1] == RegMaxRequest);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    max_request_d = max_request_q;
    if (wr_en && sel_max) begin
      max_request_d = pwdata[AmountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_request_q <= MaxRequestReset;
    end else begin
      max_request_q <= max_request_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata = {{(ApbDataW-AmountW){1'b0}}, max_request_q};
    end
  end

  assign max_request_size_o = max_request_q;

endmodule

`default_nettype wire

// ===== dv/tb_best_fit_partition_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Best-fit partition allocator testbench
// Drives define, allocate, release and unused requests through the command
// port and checks every reply against a shadow partition table kept here.
// The request limit register is rewritten over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_best_fit_partition_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bfpa_pkg::*;

  localparam int unsigned Slots         = 16;
  localparam int unsigned ClkPeriod     = 2;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned PhaseItems    = 140;
  localparam int unsigned MaxReports    = 50;
  localparam logic [1:0]  ActUnused     = 2'd3;
  localparam logic [ApbAddrW-1:0] MaxRequestAddr = ApbAddrW'(4 * RegMaxRequest);

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  bfpa_item_t          cmd_item = '0;
  logic                result_valid_o;
  bfpa_result_t        result_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Shadow of the partition table and the request limit.
  logic [AmountW-1:0] part_size  [Slots];
  logic [BaseW-1:0]   part_base  [Slots];
  logic               part_busy  [Slots];
  logic [OwnerW-1:0]  part_owner [Slots];
  int unsigned        part_count;
  logic [BaseW-1:0]   base_cursor;
  logic [AmountW-1:0] request_limit;

  bfpa_item_t   request_backlog[$];
  bfpa_result_t awaited_replies[$];
  bfpa_result_t reply_due;
  int unsigned  gap_left = 0;
  bit           gaps_on = 1'b1;
  int unsigned  idle_cycles = 0;
  int unsigned  errors = 0;
  int unsigned  requests_taken = 0;
  int unsigned  limit_writes = 0;
  int unsigned  status_tally[4] = '{default: 0};

  best_fit_partition_allocator_unit #(
    .SLOTS(Slots)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (cmd_item),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(ClkPeriod / 2.0) clk_i = ~clk_i;

  function automatic void clear_table();
    int i;
    for (i = 0; i < Slots; i++) begin
      part_size[i]  = '0;
      part_base[i]  = '0;
      part_busy[i]  = 1'b0;
      part_owner[i] = '0;
    end
    part_count    = 0;
    base_cursor   = '0;
    request_limit = MaxRequestReset;
  endfunction

  // Applies one request to the shadow table and returns the reply it earns.
  function automatic bfpa_result_t apply_request(input bfpa_item_t req);
    bfpa_result_t reply;
    logic         found;
    logic         busy_fits;
    int unsigned  best;
    int unsigned  best_left;
    int unsigned  left;
    int unsigned  freed;
    int           i;
    reply     = '0;
    found     = 1'b0;
    busy_fits = 1'b0;
    best      = 0;
    best_left = 0;
    freed     = 0;
    case (req.action)
      ActDefine: begin
        if (part_count >= Slots) begin
          reply.status = StatusTableFull;
        end else begin
          part_size[part_count]  = req.amount;
          part_base[part_count]  = base_cursor;
          part_busy[part_count]  = 1'b0;
          part_owner[part_count] = '0;
          reply.partition_index  = IndexW'(part_count);
          reply.base_address     = base_cursor;
          base_cursor            = base_cursor + BaseW'(req.amount);
          part_count++;
        end
      end
      ActAllocate: begin
        if (req.amount > request_limit) begin
          reply.status = StatusTooBig;
        end else begin
          for (i = 0; i < part_count; i++) begin
            if (req.amount <= part_size[i]) begin
              if (part_busy[i]) begin
                busy_fits = 1'b1;
              end else begin
                left = part_size[i] - req.amount;
                if (!found || left < best_left) begin
                  found     = 1'b1;
                  best      = i;
                  best_left = left;
                end
              end
            end
          end
          if (found) begin
            part_busy[best]       = 1'b1;
            part_owner[best]      = req.owner;
            reply.partition_index = IndexW'(best);
            reply.base_address    = part_base[best];
          end else if (busy_fits) begin
            reply.status = StatusMemoryFull;
          end else begin
            reply.status = StatusTooBig;
          end
        end
      end
      ActRelease: begin
        for (i = 0; i < part_count; i++) begin
          if (part_busy[i] && part_owner[i] == req.owner) begin
            part_busy[i] = 1'b0;
            freed++;
          end
        end
        reply.released_count = CountW'(freed);
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly allocations sized around the defined partitions, plus releases
  // to free them again, and some defines and unused codes as noise.
  function automatic bfpa_item_t random_request();
    bfpa_item_t  req;
    int unsigned r;
    int unsigned sz;
    req.owner  = OwnerW'($urandom);
    req.amount = AmountW'($urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      req.action = ActDefine;
    end else if (r < 14) begin
      req.action = ActUnused;
    end else if (r < 40) begin
      req.action = ActRelease;
    end else begin
      req.action = ActAllocate;
      sz = part_size[$urandom_range(0, Slots - 1)];
      r  = $urandom_range(0, 9);
      if (r == 0) begin
        req.amount = '0;
      end else if (r == 1) begin
        req.amount = '1;
      end else if (r == 2) begin
        req.amount = AmountW'(sz + 1);
      end else if (r > 3) begin
        req.amount = AmountW'(sz - $urandom_range(0, (sz < 40) ? sz : 40));
      end
    end
    return req;
  endfunction

  task automatic queue_request(input logic [1:0] act, input logic [AmountW-1:0] amt,
                               input logic [OwnerW-1:0] who);
    bfpa_item_t req;
    req.action = act;
    req.amount = amt;
    req.owner  = who;
    request_backlog.push_back(req);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || start || busy || awaited_replies.size() != 0);
  endtask

  task automatic write_limit(input logic [AmountW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MaxRequestAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    request_limit = value;
    limit_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata !== ApbDataW'(value)) begin
      $display("[%0t] limit readback: expected %0d, actual %0d", $time, value, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      cmd_item <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        reply_due = apply_request(cmd_item);
        awaited_replies.push_back(reply_due);
        status_tally[reply_due.status]++;
        requests_taken++;
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (request_backlog.size() != 0) begin
        start    <= 1'b1;
        cmd_item <= request_backlog.pop_front();
        gap_left <= gaps_on ? pick_gap() : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("[%0t] reply with no transaction pending: status %0d index %0d base %0d released %0d",
                   $time, result_o.status, result_o.partition_index, result_o.base_address,
                   result_o.released_count);
        end
      end else begin
        reply_due = awaited_replies.pop_front();
        if (result_o.status !== reply_due.status ||
            result_o.partition_index !== reply_due.partition_index ||
            result_o.base_address !== reply_due.base_address ||
            result_o.released_count !== reply_due.released_count) begin
          errors++;
        end
        if (errors <= MaxReports) begin
          if (result_o.status !== reply_due.status) begin
            $display("[%0t] status: expected %0d, actual %0d",
                     $time, reply_due.status, result_o.status);
          end
          if (result_o.partition_index !== reply_due.partition_index) begin
            $display("[%0t] partition_index: expected %0d, actual %0d",
                     $time, reply_due.partition_index, result_o.partition_index);
          end
          if (result_o.base_address !== reply_due.base_address) begin
            $display("[%0t] base_address: expected %0d, actual %0d",
                     $time, reply_due.base_address, result_o.base_address);
          end
          if (result_o.released_count !== reply_due.released_count) begin
            $display("[%0t] released_count: expected %0d, actual %0d",
                     $time, reply_due.released_count, result_o.released_count);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[%0t] no transaction for %0d cycles, %0d replies outstanding",
               $time, WatchdogLimit, awaited_replies.size());
      $display("tb_best_fit_partition_allocator_unit: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [AmountW-1:0] phase_limit [5];
    int                 p;
    int                 i;
    phase_limit[0] = 12'd4095;
    phase_limit[1] = 12'd0;
    phase_limit[2] = 12'd1800;
    phase_limit[3] = AmountW'($urandom_range(1, 4094));
    phase_limit[4] = 12'd4095;
    clear_table();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, unused code, a full table of partitions with the size
    // extremes and a tie, one define too many, then best fit and release.
    gaps_on = 1'b1;
    queue_request(ActAllocate, 12'd5, 4'd3);
    queue_request(ActRelease, 12'd0, 4'd0);
    queue_request(ActUnused, '1, '1);
    queue_request(ActDefine, 12'd0, 4'd0);
    queue_request(ActDefine, 12'd4095, 4'd15);
    queue_request(ActDefine, 12'd100, 4'd0);
    queue_request(ActDefine, 12'd100, 4'd0);
    for (i = 4; i < Slots; i++) begin
      queue_request(ActDefine, AmountW'((i % 2 == 0) ? $urandom_range(1, 400)
                                                     : $urandom_range(401, 4094)),
                    OwnerW'($urandom));
    end
    queue_request(ActDefine, 12'd77, 4'd0);
    queue_request(ActAllocate, 12'd0, 4'd1);
    queue_request(ActAllocate, 12'd4095, 4'd2);
    queue_request(ActAllocate, 12'd4095, 4'd3);
    queue_request(ActAllocate, 12'd100, 4'd4);
    queue_request(ActAllocate, 12'd90, 4'd4);
    queue_request(ActRelease, 12'd0, 4'd4);
    wait_drained();

    for (p = 0; p < 5; p++) begin
      write_limit(phase_limit[p]);
      gaps_on = (p != 2);
      for (i = 0; i < PhaseItems; i++) begin
        request_backlog.push_back(random_request());
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d transactions over %0d request limit settings.",
             requests_taken, limit_writes);
    $display("Replies: %0d ok, %0d too_big, %0d memory_full, %0d table_full.",
             status_tally[StatusOk], status_tally[StatusTooBig],
             status_tally[StatusMemoryFull], status_tally[StatusTableFull]);
    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("tb_best_fit_partition_allocator_unit: clean");
    end else begin
      $display("tb_best_fit_partition_allocator_unit: errors");
    end
    $finish;
  end

endmodule
